>>> rtl/rtpm_pkg.sv
// Shared types, constants and helpers for the RGB to two-plane mono packer.
package rtpm_pkg;

    localparam int PIX_W      = 8;
    localparam int CFG_W      = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int PROD_W     = 18;
    localparam int SUM_W      = 20;
    localparam int GRAY_DIV   = 1000;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [CFG_IDX_W-1:0] CFG_THR_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_W_RED    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_W_GREEN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_W_BLUE   = 3'd4;

    localparam logic [CFG_W-1:0] RST_THR_LOW  = 10'd50;
    localparam logic [CFG_W-1:0] RST_THR_HIGH = 10'd150;
    localparam logic [CFG_W-1:0] RST_W_RED    = 10'd212;
    localparam logic [CFG_W-1:0] RST_W_GREEN  = 10'd715;
    localparam logic [CFG_W-1:0] RST_W_BLUE   = 10'd72;

    typedef struct packed {
        logic [CFG_W-1:0] thr_low;
        logic [CFG_W-1:0] thr_high;
        logic [CFG_W-1:0] w_red;
        logic [CFG_W-1:0] w_green;
        logic [CFG_W-1:0] w_blue;
    } t_cfg;

    typedef struct packed {
        logic black;
        logic gray;
        logic last;
    } t_pix_class;

    // Threshold scaled into the weighted-sum domain.
    function automatic logic [SUM_W-1:0] f_scale_thr(input logic [CFG_W:0] thr);
        return SUM_W'(SUM_W'(thr) * SUM_W'(GRAY_DIV));
    endfunction

endpackage

>>> rtl/rtpm_front.sv
// Front end: pixel capture, weighted sum and threshold classification.
module rtpm_front import rtpm_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [PIX_W-1:0] i_pixel_red,
    input  logic [PIX_W-1:0] i_pixel_green,
    input  logic [PIX_W-1:0] i_pixel_blue,
    input  logic             i_frame_end,
    input  logic             i_q_full,
    output logic             o_push,
    output t_pix_class       o_class
);

    logic              adv;
    logic              r_v0, r_v1, r_v2;
    logic [PIX_W-1:0]  r_red, r_green, r_blue;
    logic              r_last0, r_last1, r_last2;
    logic [PROD_W-1:0] r_prod_r, r_prod_g, r_prod_b;
    logic [SUM_W-1:0]  r_sum;
    logic [SUM_W-1:0]  r_lim_black, r_lim_gray_lo, r_lim_gray_hi;

    assign adv     = !(r_v2 && i_q_full);
    assign o_stall = !adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (adv) begin
            r_v0 <= i_valid;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_red    <= i_pixel_red;
            r_green  <= i_pixel_green;
            r_blue   <= i_pixel_blue;
            r_last0  <= i_frame_end;
            r_prod_r <= PROD_W'(r_red)   * PROD_W'(i_cfg.w_red);
            r_prod_g <= PROD_W'(r_green) * PROD_W'(i_cfg.w_green);
            r_prod_b <= PROD_W'(r_blue)  * PROD_W'(i_cfg.w_blue);
            r_last1  <= r_last0;
            r_sum    <= SUM_W'(r_prod_r) + SUM_W'(r_prod_g) + SUM_W'(r_prod_b);
            r_last2  <= r_last1;
        end
    end

    // gray > t  <=>  sum >= (t+1)*1000 ; gray < t  <=>  sum < t*1000
    always_ff @(posedge i_clk) begin
        r_lim_black   <= f_scale_thr((CFG_W+1)'(i_cfg.thr_high) + 11'd1);
        r_lim_gray_lo <= f_scale_thr((CFG_W+1)'(i_cfg.thr_low) + 11'd1);
        r_lim_gray_hi <= f_scale_thr((CFG_W+1)'(i_cfg.thr_high));
    end

    assign o_push        = adv && r_v2;
    assign o_class.black = (r_sum >= r_lim_black);
    assign o_class.gray  = (r_sum >= r_lim_gray_lo) && (r_sum < r_lim_gray_hi);
    assign o_class.last  = r_last2;

endmodule

>>> rtl/rtpm_fifo.sv
// Short queue of classified pixels between front and back end.
module rtpm_fifo import rtpm_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_pix_class i_data,
    input  logic       i_pop,
    output t_pix_class o_data,
    output logic       o_full,
    output logic       o_empty
);

    t_pix_class         r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wp, r_rp;
    logic [FIFO_AW:0]   r_cnt;

    assign o_full  = (r_cnt == (FIFO_AW+1)'(FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + FIFO_AW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + FIFO_AW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + (FIFO_AW+1)'(1);
                2'b01:   r_cnt <= r_cnt - (FIFO_AW+1)'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

>>> rtl/rtpm_back.sv
// Back end: bit packing into byte pairs and output register.
module rtpm_back import rtpm_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_empty,
    input  t_pix_class       i_class,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [PIX_W-1:0] o_black_byte,
    output logic [PIX_W-1:0] o_gray_byte,
    output logic             o_frame_last
);

    logic [2:0]       r_pos;
    logic [PIX_W-1:0] r_black, r_gray;
    logic             r_o_valid;
    logic [PIX_W-1:0] r_o_black, r_o_gray;
    logic             r_o_last;
    logic [PIX_W-1:0] mask, n_black, n_gray;
    logic             emit, out_free;

    assign mask     = 8'h01 << (3'd7 - r_pos);
    assign n_black  = r_black | (i_class.black ? mask : '0);
    assign n_gray   = r_gray  | (i_class.gray  ? mask : '0);
    assign emit     = (r_pos == 3'd7) || i_class.last;
    assign out_free = !r_o_valid || !i_stall;
    assign o_pop    = !i_empty && (!emit || out_free);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_black   <= '0;
            r_gray    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (o_pop && emit) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
            if (o_pop) begin
                if (emit) begin
                    r_pos   <= '0;
                    r_black <= '0;
                    r_gray  <= '0;
                end else begin
                    r_pos   <= r_pos + 3'd1;
                    r_black <= n_black;
                    r_gray  <= n_gray;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && emit) begin
            r_o_black <= n_black;
            r_o_gray  <= n_gray;
            r_o_last  <= i_class.last;
        end
    end

    assign o_valid      = r_o_valid;
    assign o_black_byte = r_o_black;
    assign o_gray_byte  = r_o_gray;
    assign o_frame_last = r_o_last;

endmodule

>>> rtl/rgb_to_two_plane_mono_packer_unit.sv
// Top level of the RGB to two-plane mono packer: config registers and datapath.
//
// Input channel: one RGB pixel per transaction (i_valid / o_stall), with
// i_frame_end marking the last pixel of a frame. Output channel: one byte
// pair per transaction (o_valid / i_stall), black and gray planes, first
// pixel in bit 7, o_frame_last set on the pair that closes a frame.
// Gray level is (wr*R + wg*G + wb*B) / 1000, compared against two thresholds.
// Throughput: one pixel per cycle while the receiver does not stall, through the
// three-stage front pipeline feeding a four-entry queue and the packer.
// A byte pair is presented from the output register once the pixel that completes
// it (eighth pixel or frame end) has passed the front pipeline and the queue.
// When the receiver stalls, the output register holds, the queue fills and
// then o_stall rises until space frees up.
// Reset (synchronous, active low) empties the pipeline and queue, clears
// the packing position and restores the default thresholds and weights.
// Config writes (i_cfg_we, i_cfg_idx, i_cfg_data) are registered in r_cfg; the
// user must issue them only while no pixels are in flight, unchecked by the block.
module rgb_to_two_plane_mono_packer_unit import rtpm_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [PIX_W-1:0]     i_pixel_red,
    input  logic [PIX_W-1:0]     i_pixel_green,
    input  logic [PIX_W-1:0]     i_pixel_blue,
    input  logic                 i_frame_end,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [PIX_W-1:0]     o_black_byte,
    output logic [PIX_W-1:0]     o_gray_byte,
    output logic                 o_frame_last
);

    t_cfg       r_cfg;
    logic       push, pop, q_full, q_empty;
    t_pix_class push_class, head_class;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.thr_low  <= RST_THR_LOW;
            r_cfg.thr_high <= RST_THR_HIGH;
            r_cfg.w_red    <= RST_W_RED;
            r_cfg.w_green  <= RST_W_GREEN;
            r_cfg.w_blue   <= RST_W_BLUE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_THR_LOW:  r_cfg.thr_low  <= i_cfg_data;
                CFG_THR_HIGH: r_cfg.thr_high <= i_cfg_data;
                CFG_W_RED:    r_cfg.w_red    <= i_cfg_data;
                CFG_W_GREEN:  r_cfg.w_green  <= i_cfg_data;
                CFG_W_BLUE:   r_cfg.w_blue   <= i_cfg_data;
                default:      r_cfg          <= r_cfg;
            endcase
        end
    end

    rtpm_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_pixel_red   (i_pixel_red),
        .i_pixel_green (i_pixel_green),
        .i_pixel_blue  (i_pixel_blue),
        .i_frame_end   (i_frame_end),
        .i_q_full      (q_full),
        .o_push        (push),
        .o_class       (push_class)
    );

    rtpm_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_class),
        .i_pop   (pop),
        .o_data  (head_class),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    rtpm_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (q_empty),
        .i_class      (head_class),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_black_byte (o_black_byte),
        .o_gray_byte  (o_gray_byte),
        .o_frame_last (o_frame_last)
    );

endmodule
